FILE: rtl/dsfkh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsfkh_pkg - shared types and constants of the dual-seed FNV-1a key hasher
// Hash constants, prefix ROM, hex conversion and the controller/datapath
// command and status structs.
// ----------------------------------------------------------------------------
package dsfkh_pkg;

    localparam int unsigned LimitCeilingDefault = 4096;
    localparam int unsigned LimitW              = 16;
    localparam int unsigned CountW              = 13;
    localparam int unsigned PrefixLen           = 30;
    localparam int unsigned PrefixIdxW          = 5;
    localparam int unsigned KeyChars            = 32;
    localparam int unsigned CharIdxW            = 5;

    localparam logic [63:0] SeedOne = 64'd14695981039346656037;
    localparam logic [63:0] SeedTwo = 64'd7809847782465536322;

    localparam logic [7:0] ByteNul = 8'h00;
    localparam logic [7:0] ByteCr  = 8'h0d;
    localparam logic [7:0] ByteLf  = 8'h0a;

    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

    localparam logic [2:0] AddrW = 3'd3;

    typedef struct packed {
        logic                  load_seed;
        logic                  mix_prefix;
        logic [PrefixIdxW-1:0] prefix_idx;
        logic                  take_item;
        logic                  take_last;
        logic                  shift_out;
    } t_dp_cmd;

    typedef struct packed {
        logic invalid;
    } t_dp_status;

    // h * 1099511628211 = (h << 40) + (h << 8) + h * 0xb3
    function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        logic [63:0] lo;
        x  = h ^ {56'd0, b};
        lo = x * 64'd179;
        return (x << 40) + (x << 8) + lo;
    endfunction

    function automatic logic [7:0] prefix_byte(input logic [PrefixIdxW-1:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = 8'h76;
            5'd1:    b = 8'h64;
            5'd2:    b = 8'h72;
            5'd3:    b = 8'h2d;
            5'd4:    b = 8'h73;
            5'd5:    b = 8'h75;
            5'd6:    b = 8'h69;
            5'd7:    b = 8'h74;
            5'd8:    b = 8'h65;
            5'd9:    b = 8'h2d;
            5'd10:   b = 8'h72;
            5'd11:   b = 8'h65;
            5'd12:   b = 8'h63;
            5'd13:   b = 8'h6f;
            5'd14:   b = 8'h72;
            5'd15:   b = 8'h64;
            5'd16:   b = 8'h69;
            5'd17:   b = 8'h6e;
            5'd18:   b = 8'h67;
            5'd19:   b = 8'h2d;
            5'd20:   b = 8'h6e;
            5'd21:   b = 8'h61;
            5'd22:   b = 8'h74;
            5'd23:   b = 8'h69;
            5'd24:   b = 8'h76;
            5'd25:   b = 8'h65;
            5'd26:   b = 8'h2d;
            5'd27:   b = 8'h76;
            5'd28:   b = 8'h31;
            5'd29:   b = 8'h0a;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h57 + {4'd0, nib});
    endfunction

endpackage
`default_nettype wire

FILE: rtl/dual_seed_fnv1a_key_hasher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dual_seed_fnv1a_key_hasher - two-lane FNV-1a identifier key generator
// Hashes identifier bytes in two 64-bit FNV-1a lanes behind a fixed prefix
// and emits the key as 32 lowercase hex characters.
//
//   channel  direction  handshake          payload
//   input    in         i_valid / o_stall  i_id_byte, i_has_byte, i_last
//   output   out        o_valid / i_stall  o_key_char, o_key_last, o_id_invalid
//   config   in         APB, pready = 1    max_id_bytes at byte address 0
//
// One input item per cycle while o_stall is low. After a last item, 32 result
// characters (1 if invalid) as the key register shifts out a nibble per
// accepted item, then seed load and prefix absorption from ROM (one lane-pair
// mix per cycle) with o_stall high. Reset (synchronous) also starts the seed
// load and prefix absorption. Output stalls hold the key register and counter.
// ----------------------------------------------------------------------------
module dual_seed_fnv1a_key_hasher #(
    parameter int unsigned LENGTH_LIMIT_CEILING = dsfkh_pkg::LimitCeilingDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_id_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_key_char,
    output logic             o_key_last,
    output logic             o_id_invalid,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import dsfkh_pkg::*;

    localparam logic [CountW-1:0] MaxIdReset = CountW'(1024);

    logic [CountW-1:0] r_max_id_bytes;
    logic              reg_sel;
    t_dp_cmd           cmd;
    t_dp_status        status;

    assign pready  = 1'b1;
    assign reg_sel = !paddr[AddrW-1];
    assign prdata  = reg_sel ? {{(32-CountW){1'b0}}, r_max_id_bytes} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_id_bytes <= MaxIdReset;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_max_id_bytes <= pwdata[CountW-1:0];
        end
    end

    dsfkh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_last     (i_last),
        .i_stall    (i_stall),
        .i_status   (status),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_key_last (o_key_last),
        .o_cmd      (cmd)
    );

    dsfkh_datapath #(
        .LENGTH_LIMIT_CEILING (LENGTH_LIMIT_CEILING)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_id_byte      (i_id_byte),
        .i_has_byte     (i_has_byte),
        .i_max_id_bytes (r_max_id_bytes),
        .o_status       (status),
        .o_key_char     (o_key_char),
        .o_id_invalid   (o_id_invalid)
    );

endmodule
`default_nettype wire

FILE: rtl/dsfkh_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsfkh_datapath - hash lanes, length and byte checks, key shift register
// Two FNV-1a lanes mixed one byte per cycle, saturating length counter,
// forbidden-byte flag and a 128-bit register that shifts the key out.
// ----------------------------------------------------------------------------
module dsfkh_datapath #(
    parameter int unsigned LENGTH_LIMIT_CEILING = dsfkh_pkg::LimitCeilingDefault
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire dsfkh_pkg::t_dp_cmd          i_cmd,
    input  wire logic [7:0]                  i_id_byte,
    input  wire logic                        i_has_byte,
    input  wire logic [dsfkh_pkg::CountW-1:0] i_max_id_bytes,
    output dsfkh_pkg::t_dp_status            o_status,
    output logic [7:0]                       o_key_char,
    output logic                             o_id_invalid
);
    import dsfkh_pkg::*;

    localparam logic [LimitW-1:0] Ceiling = LimitW'(LENGTH_LIMIT_CEILING);

    logic [63:0]        r_lane_one, n_lane_one;
    logic [63:0]        r_lane_two, n_lane_two;
    logic [CountW-1:0]  r_count, n_count;
    logic               r_bad, n_bad;
    logic [127:0]       r_key;
    logic               r_invalid;
    logic [7:0]         mix_in;
    logic               do_mix;
    logic [LimitW-1:0]  limit;
    logic [LimitW-1:0]  count_ext;
    logic               bad_now;

    assign mix_in = i_cmd.mix_prefix ? prefix_byte(i_cmd.prefix_idx) : i_id_byte;
    assign do_mix = i_cmd.mix_prefix || (i_cmd.take_item && i_has_byte);

    assign limit = ({{(LimitW-CountW){1'b0}}, i_max_id_bytes} > Ceiling) ? Ceiling
                 : {{(LimitW-CountW){1'b0}}, i_max_id_bytes};
    assign count_ext = {{(LimitW-CountW){1'b0}}, n_count};
    assign bad_now = (n_count == '0) || (count_ext > limit) || n_bad;

    always_comb begin
        n_lane_one = r_lane_one;
        n_lane_two = r_lane_two;
        n_count    = r_count;
        n_bad      = r_bad;
        if (do_mix) begin
            n_lane_one = fnv_mix(r_lane_one, mix_in);
            n_lane_two = fnv_mix(r_lane_two, mix_in);
        end
        if (i_cmd.take_item && i_has_byte) begin
            if (r_count != CountMax) begin
                n_count = r_count + 1'b1;
            end
            if (i_id_byte == ByteNul || i_id_byte == ByteCr || i_id_byte == ByteLf) begin
                n_bad = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_bad     <= 1'b0;
            r_invalid <= 1'b0;
        end else if (i_cmd.load_seed) begin
            r_count <= '0;
            r_bad   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_bad   <= n_bad;
            if (i_cmd.take_last) begin
                r_invalid <= bad_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_seed) begin
            r_lane_one <= SeedOne;
            r_lane_two <= SeedTwo;
        end else begin
            r_lane_one <= n_lane_one;
            r_lane_two <= n_lane_two;
        end
        if (i_cmd.take_last) begin
            r_key <= {n_lane_one, n_lane_two};
        end else if (i_cmd.shift_out) begin
            r_key <= {r_key[123:0], 4'd0};
        end
    end

    assign o_status.invalid = r_invalid;
    assign o_id_invalid     = r_invalid;
    assign o_key_char       = r_invalid ? 8'd0 : hex_char(r_key[127:124]);

endmodule
`default_nettype wire

FILE: rtl/dsfkh_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsfkh_ctrl - sequencing of the key hasher
// Seed load, prefix absorption from ROM, item intake and key emission.
// ----------------------------------------------------------------------------
module dsfkh_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire logic                   i_last,
    input  wire logic                   i_stall,
    input  wire dsfkh_pkg::t_dp_status  i_status,
    output logic                        o_stall,
    output logic                        o_valid,
    output logic                        o_key_last,
    output dsfkh_pkg::t_dp_cmd          o_cmd
);
    import dsfkh_pkg::*;

    localparam logic [1:0] S_SEED   = 2'd0;
    localparam logic [1:0] S_PREFIX = 2'd1;
    localparam logic [1:0] S_IDLE   = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    localparam logic [PrefixIdxW-1:0] PrefixLast = PrefixIdxW'(PrefixLen - 1);
    localparam logic [CharIdxW-1:0]   CharLast   = CharIdxW'(KeyChars - 1);

    logic [1:0]            r_state, n_state;
    logic [PrefixIdxW-1:0] r_pidx, n_pidx;
    logic [CharIdxW-1:0]   r_cidx, n_cidx;
    logic                  in_acc;
    logic                  out_acc;

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = (r_state == S_EMIT);
    assign o_key_last = i_status.invalid || (r_cidx == CharLast);
    assign in_acc     = i_valid && !o_stall;
    assign out_acc    = o_valid && !i_stall;

    always_comb begin
        n_state = r_state;
        n_pidx  = r_pidx;
        n_cidx  = r_cidx;
        o_cmd   = '0;
        o_cmd.prefix_idx = r_pidx;
        case (r_state)
            S_SEED: begin
                o_cmd.load_seed = 1'b1;
                n_pidx  = '0;
                n_state = S_PREFIX;
            end
            S_PREFIX: begin
                o_cmd.mix_prefix = 1'b1;
                n_pidx = r_pidx + 1'b1;
                if (r_pidx == PrefixLast) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.take_item = in_acc;
                o_cmd.take_last = in_acc && i_last;
                if (in_acc && i_last) begin
                    n_cidx  = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_acc) begin
                    o_cmd.shift_out = 1'b1;
                    n_cidx = r_cidx + 1'b1;
                    if (o_key_last) begin
                        n_state = S_SEED;
                    end
                end
            end
            default: begin
                n_state = S_SEED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SEED;
            r_pidx  <= '0;
            r_cidx  <= '0;
        end else begin
            r_state <= n_state;
            r_pidx  <= n_pidx;
            r_cidx  <= n_cidx;
        end
    end

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && o_key_last |=> r_state == S_SEED)
        else $error("final item did not restart the lanes");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_last |=> o_valid && r_cidx == '0)
        else $error("last item did not start key output");

    a_invalid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_status.invalid |-> o_key_last)
        else $error("invalid result not marked final");

    a_prefix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PREFIX |-> r_pidx <= PrefixLast)
        else $error("prefix index out of range");

endmodule
`default_nettype wire
